[rtl/rms_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and constants for the running median store.
// ----------------------------------------------------------------------------
package rms_pkg;

	localparam int SAMPLE_W = 32;
	localparam int MEDIAN_W = 33;
	localparam int COUNT_W  = 7;
	localparam int CAP_W    = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REPORT = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// Broadcast to every cell of the sorted row.
	typedef struct packed {
		logic                       insert;
		logic signed [SAMPLE_W-1:0] sample;
	} rms_bcast_t;

	// Position flags decoded for one cell.
	typedef struct packed {
		logic occupied;
		logic at_tail;
		logic pick_lo;
		logic pick_hi;
	} rms_cell_ctl_t;

endpackage
`default_nettype wire

[rtl/rms_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rms_cell
// One slot of the sorted row: compare against the new sample and either
// keep its value, take the sample, or take its left neighbor's value.
// ----------------------------------------------------------------------------
module rms_cell (
	input  wire logic                                 clk,
	input  wire rms_pkg::rms_bcast_t                  bcast,
	input  wire rms_pkg::rms_cell_ctl_t               ctl,
	input  wire logic                                 left_gt,
	input  wire logic signed [rms_pkg::SAMPLE_W-1:0]  left_value,
	output logic                                      gt,
	output logic signed [rms_pkg::SAMPLE_W-1:0]       value,
	output logic [2*rms_pkg::SAMPLE_W-1:0]            leaf
);
	import rms_pkg::*;

	logic signed [SAMPLE_W-1:0] value_q;
	logic signed [SAMPLE_W-1:0] value_d;

	always_comb begin
		gt      = ctl.occupied && (value_q > bcast.sample);
		value_d = value_q;
		if (bcast.insert) begin
			// Everything above the insertion point moves one slot to the right.
			if (left_gt) begin
				value_d = left_value;
			end else if (gt || ctl.at_tail) begin
				value_d = bcast.sample;
			end
		end
		leaf = {(ctl.pick_lo ? value_d : '0), (ctl.pick_hi ? value_d : '0)};
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule
`default_nettype wire

[rtl/rms_or_tree.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rms_or_tree
// Registered four-way OR tree that gathers the selected cell values, with
// a valid bit and a tag that travel alongside each level.
// ----------------------------------------------------------------------------
module rms_or_tree #(
	parameter int N  = 64,
	parameter int W  = 64,
	parameter int TW = 9
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic [N-1:0][W-1:0] leaf,
	input  wire logic                in_vld,
	input  wire logic [TW-1:0]       in_tag,
	output logic                     out_vld,
	output logic [TW-1:0]            out_tag,
	output logic [W-1:0]             root
);
	localparam int L     = ($clog2(N) + 1) / 2;
	localparam int P     = 1 << (2 * L);
	localparam int NODES = (P - 1) / 3;

	function automatic int lvl_off(input int k);
		int o;
		o = 0;
		for (int j = 1; j < k; j++) begin
			o = o + (P >> (2 * j));
		end
		return o;
	endfunction

	logic [P-1:0][W-1:0]     pad;
	logic [NODES-1:0][W-1:0] node_q;
	logic [NODES-1:0][W-1:0] node_d;
	logic [L-1:0]            vld_q;
	logic [L-1:0][TW-1:0]    tag_q;

	for (genvar i = 0; i < P; i++) begin : g_pad
		if (i < N) begin : g_used
			assign pad[i] = leaf[i];
		end else begin : g_zero
			assign pad[i] = '0;
		end
	end

	always_comb begin
		node_d = node_q;
		for (int k = 1; k <= L; k++) begin
			for (int n = 0; n < (P >> (2 * k)); n++) begin
				if (k == 1) begin
					node_d[n] = pad[4*n] | pad[4*n+1] | pad[4*n+2] | pad[4*n+3];
				end else begin
					node_d[lvl_off(k)+n] = node_q[lvl_off(k-1)+4*n]
						| node_q[lvl_off(k-1)+4*n+1]
						| node_q[lvl_off(k-1)+4*n+2]
						| node_q[lvl_off(k-1)+4*n+3];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			node_q   <= node_d;
			tag_q[0] <= in_tag;
			for (int k = 1; k < L; k++) begin
				tag_q[k] <= tag_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q[0] <= in_vld;
			for (int k = 1; k < L; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign root    = node_q[NODES-1];
	assign out_vld = vld_q[L-1];
	assign out_tag = tag_q[L-1];

endmodule
`default_nettype wire

[rtl/running_median_store_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// running_median_store_unit
// Sorted sample store that reports twice the running median per transaction.
// ----------------------------------------------------------------------------
// Samples are held in ascending order in a row of DEPTH compare-and-shift
// cells, so an add is inserted in the cycle it is accepted. One transaction
// is accepted per cycle whenever the output register is free or being taken.
// Each result travels from its input transaction through the registered
// four-way OR tree that gathers the two middle values out of the cell row,
// then through the output register. No clearing pass is needed after
// reset, and the capacity register may be written only while the block
// is idle.
module running_median_store_unit #(
	parameter int DEPTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [rms_pkg::CAP_W-1:0]           cfg_wr_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          command,
	input  wire logic signed [rms_pkg::SAMPLE_W-1:0] sample,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     status,
	output logic signed [rms_pkg::MEDIAN_W-1:0]      median_twice,
	output logic [rms_pkg::COUNT_W-1:0]              count
);
	import rms_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > CAP_W) ? CW : CAP_W;
	localparam int TW = CW + 2;

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_next;
	logic [CW-1:0]    count_m1;
	logic [CW-1:0]    lo_idx;
	logic [CW-1:0]    hi_idx;
	logic             adv;
	logic             accept;
	logic             full;
	logic             is_add;
	logic             is_clear;
	logic             do_ins;
	logic             status_n;

	rms_bcast_t                          bcast;
	rms_cell_ctl_t [DEPTH-1:0]           cell_ctl;
	logic [DEPTH-1:0]                    cell_gt;
	logic signed [SAMPLE_W-1:0]          cell_value [DEPTH];
	logic [DEPTH-1:0][2*SAMPLE_W-1:0]    cell_leaf;

	logic                  tree_vld;
	logic [TW-1:0]         tree_tag;
	logic [2*SAMPLE_W-1:0] tree_root;
	logic [CW-1:0]         tree_count;
	logic                  tree_empty;
	logic                  tree_status;
	logic signed [MEDIAN_W-1:0] mid_sum;

	logic                       out_valid_q;
	logic                       status_q;
	logic signed [MEDIAN_W-1:0] median_q;
	logic [COUNT_W-1:0]         count_out_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;
	assign accept   = in_valid && adv;

	always_comb begin
		is_add   = 1'b0;
		is_clear = 1'b0;
		case (command)
			CMD_ADD:    is_add = 1'b1;
			CMD_CLEAR:  is_clear = 1'b1;
			CMD_REPORT: is_add = 1'b0;
			default:    is_add = 1'b0;
		endcase
	end

	// The capacity saturates at the number of cells.
	assign full = (MW'(count_q) >= MW'(cap_q)) || (MW'(count_q) >= MW'(DEPTH));

	assign do_ins   = accept && is_add && !full;
	assign status_n = is_add && full;

	always_comb begin
		count_next = count_q;
		if (accept) begin
			if (is_clear) begin
				count_next = '0;
			end else if (do_ins) begin
				count_next = count_q + 1'b1;
			end
		end
	end

	// Middle positions after this transaction; they coincide for an odd count.
	assign count_m1 = count_next - 1'b1;
	assign lo_idx   = count_m1 >> 1;
	assign hi_idx   = count_next >> 1;

	assign bcast.insert = do_ins;
	assign bcast.sample = sample;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign cell_ctl[i].occupied = CW'(i) < count_q;
		assign cell_ctl[i].at_tail  = CW'(i) == count_q;
		assign cell_ctl[i].pick_lo  = CW'(i) == lo_idx;
		assign cell_ctl[i].pick_hi  = CW'(i) == hi_idx;

		if (i == 0) begin : g_head
			rms_cell u_cell (
				.clk        (clk),
				.bcast      (bcast),
				.ctl        (cell_ctl[i]),
				.left_gt    (1'b0),
				.left_value ('0),
				.gt         (cell_gt[i]),
				.value      (cell_value[i]),
				.leaf       (cell_leaf[i])
			);
		end else begin : g_body
			rms_cell u_cell (
				.clk        (clk),
				.bcast      (bcast),
				.ctl        (cell_ctl[i]),
				.left_gt    (cell_gt[i-1]),
				.left_value (cell_value[i-1]),
				.gt         (cell_gt[i]),
				.value      (cell_value[i]),
				.leaf       (cell_leaf[i])
			);
		end
	end

	rms_or_tree #(
		.N  (DEPTH),
		.W  (2 * SAMPLE_W),
		.TW (TW)
	) u_tree (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.leaf    (cell_leaf),
		.in_vld  (accept),
		.in_tag  ({status_n, (count_next == '0), count_next}),
		.out_vld (tree_vld),
		.out_tag (tree_tag),
		.root    (tree_root)
	);

	assign tree_status = tree_tag[TW-1];
	assign tree_empty  = tree_tag[TW-2];
	assign tree_count  = tree_tag[CW-1:0];
	assign mid_sum = MEDIAN_W'($signed(tree_root[2*SAMPLE_W-1:SAMPLE_W]))
		+ MEDIAN_W'($signed(tree_root[SAMPLE_W-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			count_q <= count_next;
			if (adv) begin
				out_valid_q <= tree_vld;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q    <= tree_status;
			median_q    <= tree_empty ? '0 : mid_sum;
			count_out_q <= COUNT_W'(tree_count);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign median_twice = median_q;
	assign count        = count_out_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stored count exceeds the number of cells");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (command == CMD_CLEAR) |=> count_q == '0)
		else $error("clear transaction did not empty the store");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (command == CMD_ADD) && full |=> $stable(count_q))
		else $error("rejected add changed the stored count");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("accepted add did not advance the stored count by one");
`endif

endmodule
`default_nettype wire

[test/running_median_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// running_median_checker
// Watches both channels of the running median store, keeps its own sorted
// copy of the samples, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module running_median_checker #(
	parameter int DEPTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [rms_pkg::CAP_W-1:0]           cfg_wr_data,
	input  wire logic                                in_valid,
	input  wire logic                                in_ready,
	input  wire logic [1:0]                          command,
	input  wire logic signed [rms_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                out_valid,
	input  wire logic                                out_ready,
	input  wire logic                                status,
	input  wire logic signed [rms_pkg::MEDIAN_W-1:0] median_twice,
	input  wire logic [rms_pkg::COUNT_W-1:0]         count,
	output int                                       errors,
	output int                                       outstanding,
	output int                                       results_seen,
	output int                                       full_rejects,
	output int                                       peak_count
);
	import rms_pkg::*;

	typedef struct packed {
		logic                       status;
		logic signed [MEDIAN_W-1:0] median_twice;
		logic [COUNT_W-1:0]         count;
	} median_result_t;

	logic signed [SAMPLE_W-1:0] sorted_row [DEPTH];
	int                         held_count = 0;
	logic [CAP_W-1:0]           cap_reg = CAP_RESET;
	median_result_t             expected_medians [$];
	int                         err_tally = 0;
	int                         seen_tally = 0;
	int                         reject_tally = 0;
	int                         peak_tally = 0;

	assign errors       = err_tally;
	assign results_seen = seen_tally;
	assign full_rejects = reject_tally;
	assign peak_count   = peak_tally;

	// Applies one transaction to the shadow store and returns the result it must produce.
	function automatic median_result_t apply_item(input logic [1:0] op,
			input logic signed [SAMPLE_W-1:0] value);
		median_result_t             r;
		int                         pos;
		int                         lim;
		logic signed [SAMPLE_W-1:0] lo;
		logic signed [SAMPLE_W-1:0] hi;
		r.status = 1'b0;
		lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
		case (op)
			CMD_ADD: begin
				if (held_count >= lim) begin
					r.status = 1'b1;
					reject_tally++;
				end else begin
					// Equal samples stay ahead of the new one.
					pos = held_count;
					while (pos > 0 && sorted_row[pos-1] > value) begin
						sorted_row[pos] = sorted_row[pos-1];
						pos--;
					end
					sorted_row[pos] = value;
					held_count++;
				end
			end
			CMD_CLEAR: held_count = 0;
			default: ;
		endcase
		if (held_count == 0) begin
			r.median_twice = '0;
		end else begin
			hi = sorted_row[held_count/2];
			lo = (held_count % 2 == 1) ? hi : sorted_row[held_count/2 - 1];
			r.median_twice = $signed({lo[SAMPLE_W-1], lo}) + $signed({hi[SAMPLE_W-1], hi});
		end
		r.count = COUNT_W'(held_count);
		if (held_count > peak_tally)
			peak_tally = held_count;
		return r;
	endfunction

	task automatic compare_field(input string what, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
			err_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		median_result_t want;
		if (!arst_n) begin
			held_count = 0;
			cap_reg = CAP_RESET;
			expected_medians.delete();
			outstanding <= 0;
		end else begin
			if (cfg_wr_en)
				cap_reg = cfg_wr_data;
			// Retire the output side first so a result never meets its own input.
			if (out_valid && out_ready) begin
				seen_tally++;
				if (expected_medians.size() == 0) begin
					$display("%0t: result with no transaction waiting: %s %0b, %0d, %0d",
						$time, "status, median, count", status, median_twice, count);
					err_tally++;
				end else begin
					want = expected_medians.pop_front();
					compare_field("status", want.status, status);
					compare_field("median_twice", $signed(want.median_twice), median_twice);
					compare_field("count", want.count, count);
				end
			end
			if (in_valid && in_ready)
				expected_medians.push_back(apply_item(command, sample));
			outstanding <= expected_medians.size();
		end
	end

endmodule
`default_nettype wire

[test/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Regression for the running median store: directed corner transactions,
// then random phases over many capacities with sender gaps, receiver stalls,
// a long output hold-off and drain pauses, all checked by a shadow store.
// ----------------------------------------------------------------------------
module tb_top;
	import rms_pkg::*;

	localparam int         DEPTH       = 64;
	localparam int         HOLD_CYCLES = 200;
	localparam int         RUN_LIMIT   = 400000;
	localparam logic [1:0] CMD_SPARE   = 2'd3;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wr_en;
	logic [CAP_W-1:0]           cfg_wr_data;
	logic                       in_valid;
	logic                       in_ready;
	logic [1:0]                 command;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       out_valid;
	logic                       out_ready;
	logic                       status;
	logic signed [MEDIAN_W-1:0] median_twice;
	logic [COUNT_W-1:0]         count;

	int errors;
	int outstanding;
	int results_seen;
	int full_rejects;
	int peak_count;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_asks      = 0;
	int items_sent     = 0;

	running_median_store_unit #(.DEPTH(DEPTH)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.median_twice (median_twice),
		.count        (count)
	);

	running_median_checker #(.DEPTH(DEPTH)) median_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.median_twice (median_twice),
		.count        (count),
		.errors       (errors),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.full_rejects (full_rejects),
		.peak_count   (peak_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("running_median_store_unit regression: fail");
		$finish;
	end

	// Output side: random stalls, or a long hold-off when the stimulus asks for one.
	initial begin
		int hold_done;
		int k;
		hold_done = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_done) begin
				hold_done = hold_asks;
				out_ready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [SAMPLE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= op;
		sample   <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// The checker's count is registered, so wait for a clock edge before trusting it.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		wait_drained();
		repeat (6) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(input int n, input int cap, input int idle, input int stall,
			input int clear_pct, input bit drain_bursts, input bit long_hold);
		int                  k;
		int                  r;
		logic [1:0]          op;
		logic [SAMPLE_W-1:0] value;
		set_capacity(CAP_W'(cap));
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		for (k = 0; k < n; k++) begin
			if (long_hold && k == n / 4)
				hold_asks++;
			if (drain_bursts && k % 9 == 8)
				wait_drained();
			r = $urandom_range(99);
			if (r < clear_pct)
				op = CMD_CLEAR;
			else if (r < clear_pct + 3)
				op = CMD_SPARE;
			else if (r < clear_pct + 15)
				op = CMD_REPORT;
			else
				op = CMD_ADD;
			// Small values make ties common; extremes stress the 33-bit sum.
			case ($urandom_range(9))
				0: begin
					case ($urandom_range(3))
						0: value = 32'h8000_0000;
						1: value = 32'h7FFF_FFFF;
						2: value = 32'h0000_0000;
						default: value = 32'hFFFF_FFFF;
					endcase
				end
				1, 2, 3: value = 32'($urandom_range(16)) - 32'd8;
				default: value = $urandom;
			endcase
			send_item(op, value);
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = CAP_RESET;
		in_valid    = 1'b0;
		command     = CMD_REPORT;
		sample      = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners at the reset capacity.
		send_item(CMD_REPORT, 32'd0);
		send_item(CMD_CLEAR, 32'd0);
		send_item(CMD_ADD, 32'h8000_0000);
		send_item(CMD_ADD, 32'h7FFF_FFFF);
		send_item(CMD_ADD, 32'h7FFF_FFFF);
		send_item(CMD_SPARE, 32'hFFFF_FFFF);
		send_item(CMD_ADD, 32'd0);
		send_item(CMD_ADD, 32'd0);
		send_item(CMD_ADD, 32'hFFFF_FFFF);
		send_item(CMD_CLEAR, 32'd0);
		send_item(CMD_ADD, 32'hFFFF_FFFF);

		// Small capacity: fill, then rejected adds.
		set_capacity(7'd2);
		send_item(CMD_ADD, 32'd5);
		send_item(CMD_ADD, 32'd5);
		send_item(CMD_ADD, 32'd7);
		send_item(CMD_REPORT, 32'd0);

		// Capacity lowered below the stored count keeps the samples.
		set_capacity(7'd1);
		send_item(CMD_ADD, 32'd9);
		send_item(CMD_REPORT, 32'd0);
		send_item(CMD_CLEAR, 32'd0);
		send_item(CMD_ADD, 32'hFFFF_FFFD);
		send_item(CMD_ADD, 32'd4);

		// Zero capacity rejects everything.
		set_capacity(7'd0);
		send_item(CMD_CLEAR, 32'd0);
		send_item(CMD_ADD, 32'd1);

		run_phase(300, 127, 0, 0, 1, 1'b0, 1'b0);
		run_phase(250, 64, 59, 0, 2, 1'b0, 1'b0);
		run_phase(200, 5, 0, 59, 8, 1'b0, 1'b0);
		run_phase(250, $urandom_range(64, 1), 10, 10, 3, 1'b0, 1'b1);
		run_phase(150, 1, 0, 0, 10, 1'b0, 1'b0);
		run_phase(60, 0, 10, 10, 5, 1'b0, 1'b0);
		run_phase(250, 40, 59, 10, 3, 1'b1, 1'b0);
		run_phase(100, 64, 0, 0, 0, 1'b0, 1'b0);
		run_phase(240, $urandom_range(127, 0), 0, 59, 3, 1'b0, 1'b0);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d transactions, checked %0d results across capacities 0 to 127.",
			items_sent, results_seen);
		$display("Adds rejected on a full store: %0d; largest sample count held: %0d.",
			full_rejects, peak_count);
		if (errors + outstanding == 0)
			$display("running_median_store_unit regression: pass");
		else
			$display("running_median_store_unit regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
